### rtl/core/inpt_pkg.sv
// Package for the identifier/number/punctuation tokenizer.
// Token kinds, result and byte-class types, saturation and keyword helpers.
// No dependencies.
`timescale 1ns / 1ps

package inpt_pkg;

  localparam int unsigned MAX_TEXT_BYTES = 65536;
  localparam int unsigned POS_W = 16;
  localparam int unsigned LIMIT = (MAX_TEXT_BYTES - 1 < 65535) ? MAX_TEXT_BYTES - 1 : 65535;
  localparam logic [POS_W-1:0] LIMIT_W = POS_W'(LIMIT);

  localparam logic [3:0] KIND_IDENT  = 4'd0;
  localparam logic [3:0] KIND_DEF    = 4'd1;
  localparam logic [3:0] KIND_EXTERN = 4'd2;
  localparam logic [3:0] KIND_NUMBER = 4'd3;
  localparam logic [3:0] KIND_LPAREN = 4'd4;
  localparam logic [3:0] KIND_RPAREN = 4'd5;
  localparam logic [3:0] KIND_PLUS   = 4'd6;
  localparam logic [3:0] KIND_MINUS  = 4'd7;
  localparam logic [3:0] KIND_STAR   = 4'd8;
  localparam logic [3:0] KIND_COMMA  = 4'd9;
  localparam logic [3:0] KIND_DOT    = 4'd10;
  localparam logic [3:0] KIND_EOF    = 4'd11;
  localparam logic [3:0] KIND_ERROR  = 4'd12;

  localparam logic [2:0] DEF_LEN    = 3'd3;
  localparam logic [2:0] EXTERN_LEN = 3'd6;

  typedef struct packed {
    logic [3:0]       kind;
    logic [POS_W-1:0] start;
    logic [POS_W-1:0] length;
    logic [7:0]       bad;
    logic             last;
  } res_t;

  typedef struct packed {
    logic       is_letter;
    logic       is_digit;
    logic       is_space;
    logic       is_punct;
    logic [3:0] punct_kind;
  } cls_t;

  function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
    return (v < LIMIT_W) ? v + POS_W'(1) : LIMIT_W;
  endfunction

  function automatic logic [7:0] kw_def_char(input logic [1:0] i);
    logic [7:0] c;
    case (i)
      2'd0:    c = "d";
      2'd1:    c = "e";
      default: c = "f";
    endcase
    return c;
  endfunction

  function automatic logic [7:0] kw_extern_char(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0:    c = "e";
      3'd1:    c = "x";
      3'd2:    c = "t";
      3'd3:    c = "e";
      3'd4:    c = "r";
      default: c = "n";
    endcase
    return c;
  endfunction

endpackage

### rtl/core/inpt_classify.sv
// Byte classifier: letter, digit, whitespace and punctuation decode.
// Depends on inpt_pkg.
`timescale 1ns / 1ps

module inpt_classify (
  input  logic [7:0]    char_byte,
  output inpt_pkg::cls_t cls
);
  import inpt_pkg::*;

  always_comb begin
    cls = '0;
    cls.is_letter = (char_byte >= "A" && char_byte <= "Z") ||
                    (char_byte >= "a" && char_byte <= "z");
    cls.is_digit  = (char_byte >= "0" && char_byte <= "9");
    cls.is_space  = (char_byte == 8'd32) || (char_byte >= 8'd9 && char_byte <= 8'd13);
    cls.is_punct  = 1'b1;
    unique case (char_byte)
      "(":     cls.punct_kind = KIND_LPAREN;
      ")":     cls.punct_kind = KIND_RPAREN;
      "+":     cls.punct_kind = KIND_PLUS;
      "-":     cls.punct_kind = KIND_MINUS;
      "*":     cls.punct_kind = KIND_STAR;
      ",":     cls.punct_kind = KIND_COMMA;
      ".":     cls.punct_kind = KIND_DOT;
      default: begin
        cls.is_punct   = 1'b0;
        cls.punct_kind = KIND_IDENT;
      end
    endcase
  end

endmodule

### rtl/core/inpt_scan.sv
// Scanner state and token generation: up to two results per transfer.
// Depends on inpt_pkg; takes byte classes from inpt_classify.
`timescale 1ns / 1ps

module inpt_scan (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic [7:0]                 char_byte,
  input  logic                       end_of_text,
  input  inpt_pkg::cls_t             cls,
  output inpt_pkg::res_t             res0,
  output inpt_pkg::res_t             res1,
  output logic [1:0]                 res_cnt
);
  import inpt_pkg::*;

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_IDENT  = 2'd1;
  localparam logic [1:0] MODE_NUMBER = 2'd2;
  localparam logic [1:0] MODE_HALT   = 2'd3;

  logic [1:0]       mode_r, mode_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] run_start_r, run_start_nxt;
  logic [POS_W-1:0] run_len_r, run_len_nxt;
  logic             def_r, def_nxt;
  logic             ext_r, ext_nxt;

  res_t flush_res, tok_res;
  logic flush_v, tok_v;

  always_comb begin
    flush_v = (mode_r == MODE_IDENT) || (mode_r == MODE_NUMBER);
    flush_res        = '0;
    flush_res.start  = run_start_r;
    flush_res.length = run_len_r;
    if (mode_r == MODE_NUMBER) begin
      flush_res.kind = KIND_NUMBER;
    end else if (def_r && run_len_r == POS_W'(DEF_LEN)) begin
      flush_res.kind = KIND_DEF;
    end else if (ext_r && run_len_r == POS_W'(EXTERN_LEN)) begin
      flush_res.kind = KIND_EXTERN;
    end else begin
      flush_res.kind = KIND_IDENT;
    end
  end

  always_comb begin
    mode_nxt      = mode_r;
    pos_nxt       = pos_r;
    run_start_nxt = run_start_r;
    run_len_nxt   = run_len_r;
    def_nxt       = def_r;
    ext_nxt       = ext_r;
    tok_v         = 1'b0;
    tok_res       = '0;
    res0          = '0;
    res1          = '0;
    res_cnt       = 2'd0;

    if (end_of_text) begin
      tok_res.kind  = KIND_EOF;
      tok_res.start = pos_r;
      tok_res.last  = 1'b1;
      if (flush_v) begin
        res0    = flush_res;
        res1    = tok_res;
        res_cnt = 2'd2;
      end else begin
        res0    = tok_res;
        res_cnt = 2'd1;
      end
      mode_nxt      = MODE_IDLE;
      pos_nxt       = '0;
      run_start_nxt = '0;
      run_len_nxt   = '0;
      def_nxt       = 1'b0;
      ext_nxt       = 1'b0;
    end else if (mode_r != MODE_HALT) begin
      pos_nxt = sat_inc(pos_r);
      if (mode_r == MODE_IDENT && (cls.is_letter || cls.is_digit)) begin
        def_nxt = def_r && (run_len_r < POS_W'(DEF_LEN)) &&
                  (kw_def_char(run_len_r[1:0]) == char_byte);
        ext_nxt = ext_r && (run_len_r < POS_W'(EXTERN_LEN)) &&
                  (kw_extern_char(run_len_r[2:0]) == char_byte);
        run_len_nxt = sat_inc(run_len_r);
      end else if (mode_r == MODE_NUMBER && cls.is_digit) begin
        run_len_nxt = sat_inc(run_len_r);
      end else begin
        mode_nxt = MODE_IDLE;
        tok_res.start  = pos_r;
        tok_res.length = POS_W'(1);
        if (cls.is_space) begin
          tok_v = 1'b0;
        end else if (cls.is_letter) begin
          mode_nxt      = MODE_IDENT;
          run_start_nxt = pos_r;
          run_len_nxt   = POS_W'(1);
          def_nxt       = (char_byte == kw_def_char(2'd0));
          ext_nxt       = (char_byte == kw_extern_char(3'd0));
        end else if (cls.is_digit) begin
          mode_nxt      = MODE_NUMBER;
          run_start_nxt = pos_r;
          run_len_nxt   = POS_W'(1);
        end else if (cls.is_punct) begin
          tok_v        = 1'b1;
          tok_res.kind = cls.punct_kind;
        end else begin
          tok_v        = 1'b1;
          tok_res.kind = KIND_ERROR;
          tok_res.bad  = char_byte;
          mode_nxt     = MODE_HALT;
        end
        tok_res.last = 1'b1;
        if (flush_v) begin
          res0      = flush_res;
          res0.last = !tok_v;
          if (tok_v) begin
            res1    = tok_res;
            res_cnt = 2'd2;
          end else begin
            res_cnt = 2'd1;
          end
        end else if (tok_v) begin
          res0    = tok_res;
          res_cnt = 2'd1;
        end
      end
    end else begin
      // halted after an error: only the position moves
      pos_nxt = sat_inc(pos_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      pos_r       <= '0;
      run_start_r <= '0;
      run_len_r   <= '0;
      def_r       <= 1'b0;
      ext_r       <= 1'b0;
    end else if (accept) begin
      mode_r      <= mode_nxt;
      pos_r       <= pos_nxt;
      run_start_r <= run_start_nxt;
      run_len_r   <= run_len_nxt;
      def_r       <= def_nxt;
      ext_r       <= ext_nxt;
    end
  end

  // an error transfer always halts the scanner
  a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && res_cnt != 2'd0 && !end_of_text &&
     (res0.kind == KIND_ERROR || (res_cnt == 2'd2 && res1.kind == KIND_ERROR)))
    |=> (mode_r == MODE_HALT))
    else $error("error result without halt");

  // end of text always re-arms the scanner at offset zero
  a_eot_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && end_of_text) |=> (mode_r == MODE_IDLE && pos_r == '0))
    else $error("end of text did not re-arm");

  // only end of text takes the scanner out of halt
  a_halt_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_HALT && !(accept && end_of_text)) |=> (mode_r == MODE_HALT))
    else $error("scanner left halt before end of text");

endmodule

### rtl/core/inpt_outq.sv
// Three-entry result queue between the scanner and the output channel.
// Takes up to two results per cycle while can_push shows room; depends on inpt_pkg.
`timescale 1ns / 1ps

module inpt_outq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  logic [1:0]      push_cnt,
  input  inpt_pkg::res_t  push0,
  input  inpt_pkg::res_t  push1,
  output logic            can_push,
  output logic            out_valid,
  input  logic            out_ready,
  output inpt_pkg::res_t  head
);
  import inpt_pkg::*;

  localparam int unsigned DEPTH = 3;

  res_t       q_r [DEPTH];
  res_t       q_nxt [DEPTH];
  logic [1:0] count_r, count_nxt;
  logic       pop;
  logic [1:0] base;
  logic [1:0] add;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count_r != 2'd0);
  assign head      = q_r[0];
  // room for two more results after this cycle's transfer out
  assign can_push  = (count_r <= 2'd1) || (count_r == 2'd2 && pop);
  assign base      = count_r - {1'b0, pop};
  assign add       = push ? push_cnt : 2'd0;
  assign count_nxt = base + add;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      if (pop && i < DEPTH - 1) begin
        q_nxt[i] = q_r[i+1];
      end else begin
        q_nxt[i] = q_r[i];
      end
      if (add != 2'd0 && 2'(i) == base) begin
        q_nxt[i] = push0;
      end
      if (add == 2'd2 && 2'(i) == base + 2'd1) begin
        q_nxt[i] = push1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> ({1'b0, base} + {1'b0, add} <= 3'(DEPTH)))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> can_push)
    else $error("push without room");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (!push && !pop) |=> $stable(count_r))
    else $error("queue count moved while idle");

endmodule

### rtl/core/ident_number_punct_tokenizer_top.sv
// Identifier / number / punctuation tokenizer, one text byte per transfer.
// Results are registered in the result queue before they show on out_valid.
// Throughput: one byte per cycle while the three-entry result queue has room
// for two more results; input stalls otherwise, which a byte with two results
// (flush plus token) can bring about while the output drains. Synchronous
// active-low reset: scanner idle at offset zero, result queue empty.
`timescale 1ns / 1ps

module ident_number_punct_tokenizer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_byte,
  input  logic        in_end_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_token_kind,
  output logic [15:0] out_token_start,
  output logic [15:0] out_token_length,
  output logic [7:0]  out_bad_byte,
  output logic        out_last_of_run
);
  import inpt_pkg::*;

  cls_t       cls;
  res_t       res0, res1, head;
  logic [1:0] res_cnt;
  logic       accept;

  assign accept = in_valid && in_ready;

  inpt_classify u_classify (
    .char_byte (in_char_byte),
    .cls       (cls)
  );

  inpt_scan u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .char_byte   (in_char_byte),
    .end_of_text (in_end_of_text),
    .cls         (cls),
    .res0        (res0),
    .res1        (res1),
    .res_cnt     (res_cnt)
  );

  inpt_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_cnt  (res_cnt),
    .push0     (res0),
    .push1     (res1),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_token_kind   = head.kind;
  assign out_token_start  = head.start;
  assign out_token_length = head.length;
  assign out_bad_byte     = head.bad;
  assign out_last_of_run  = head.last;

endmodule

### dv/tb.sv
// Testbench for ident_number_punct_tokenizer_top: a short table of directed bytes,
// random texts and a receiver hold-off, all checked by a byte-level scanner.
// Depends on inpt_pkg and the top-level RTL.
`timescale 1ns / 1ps

module tb;
  import inpt_pkg::*;

  typedef enum logic [1:0] {SCAN_IDLE, SCAN_IDENT, SCAN_NUMBER, SCAN_HALTED} scan_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
    logic       typed;
    res_t       want;
  } dir_row_t;

  localparam logic [23:0] KW_DEF      = "def";
  localparam logic [47:0] KW_EXTERN   = "extern";
  localparam logic [55:0] PUNCT_SET   = "()+-*,.";
  localparam int          RAND_ITEMS  = 1700;
  localparam int          HOLD_CYCLES = 64;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_char_byte;
  logic        in_end_of_text;
  logic        out_valid;
  logic        out_ready;
  logic [3:0]  out_token_kind;
  logic [15:0] out_token_start;
  logic [15:0] out_token_length;
  logic [7:0]  out_bad_byte;
  logic        out_last_of_run;

  ident_number_punct_tokenizer_top i_dut (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // scanner state
  scan_e       sc_mode;
  logic [15:0] sc_pos;
  logic [15:0] sc_start;
  logic [15:0] sc_len;
  logic        sc_def;
  logic        sc_ext;

  res_t     step_out[$];
  res_t     pending_tokens[$];
  dir_row_t dir_rows[$];

  int mismatches    = 0;
  int tokens_seen   = 0;
  int live_items    = 0;
  int texts         = 0;
  int bad_texts     = 0;
  int tx_burst_left = 0;
  int rx_burst_left = 0;
  int rx_stall      = 0;
  int hold_left     = 0;
  bit hold_arm      = 1'b0;

  function automatic bit is_alpha(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit is_num(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_ws(input logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // anything that is not punctuation maps to the error kind
  function automatic logic [3:0] punct_of(input logic [7:0] c);
    case (c)
      "(":     return KIND_LPAREN;
      ")":     return KIND_RPAREN;
      "+":     return KIND_PLUS;
      "-":     return KIND_MINUS;
      "*":     return KIND_STAR;
      ",":     return KIND_COMMA;
      ".":     return KIND_DOT;
      default: return KIND_ERROR;
    endcase
  endfunction

  function automatic logic [15:0] pos_bump(input logic [15:0] v);
    return (v < LIMIT_W) ? v + 16'd1 : LIMIT_W;
  endfunction

  function automatic logic [7:0] kw_def_at(input int i);
    return (i < 3) ? KW_DEF[8*(2-i) +: 8] : 8'h00;
  endfunction

  function automatic logic [7:0] kw_ext_at(input int i);
    return (i < 6) ? KW_EXTERN[8*(5-i) +: 8] : 8'h00;
  endfunction

  function automatic void scan_reset();
    sc_mode  = SCAN_IDLE;
    sc_pos   = '0;
    sc_start = '0;
    sc_len   = '0;
    sc_def   = 1'b0;
    sc_ext   = 1'b0;
  endfunction

  function automatic void flush_run();
    res_t r;
    if (sc_mode == SCAN_IDENT || sc_mode == SCAN_NUMBER) begin
      r = '0;
      if (sc_mode == SCAN_NUMBER) r.kind = KIND_NUMBER;
      else if (sc_def && sc_len == 16'd3) r.kind = KIND_DEF;
      else if (sc_ext && sc_len == 16'd6) r.kind = KIND_EXTERN;
      else r.kind = KIND_IDENT;
      r.start  = sc_start;
      r.length = sc_len;
      step_out.push_back(r);
      sc_mode = SCAN_IDLE;
    end
  endfunction

  // Tokens caused by one transfer land in step_out, last flag on the final one.
  function automatic void scan_byte(input logic [7:0] c, input logic eot);
    res_t r;
    step_out.delete();
    if (eot) begin
      flush_run();
      r = '0;
      r.kind  = KIND_EOF;
      r.start = sc_pos;
      step_out.push_back(r);
      scan_reset();
    end else begin
      if (sc_mode == SCAN_IDENT && (is_alpha(c) || is_num(c))) begin
        sc_def = sc_def && sc_len < 16'd3 && kw_def_at(int'(sc_len)) == c;
        sc_ext = sc_ext && sc_len < 16'd6 && kw_ext_at(int'(sc_len)) == c;
        sc_len = pos_bump(sc_len);
      end else if (sc_mode == SCAN_NUMBER && is_num(c)) begin
        sc_len = pos_bump(sc_len);
      end else if (sc_mode != SCAN_HALTED) begin
        flush_run();
        if (is_alpha(c) || is_num(c)) begin
          if (is_alpha(c)) sc_mode = SCAN_IDENT;
          else sc_mode = SCAN_NUMBER;
          sc_start = sc_pos;
          sc_len   = 16'd1;
          sc_def   = (c == "d");
          sc_ext   = (c == "e");
        end else if (!is_ws(c)) begin
          r = '0;
          r.kind   = punct_of(c);
          r.start  = sc_pos;
          r.length = 16'd1;
          if (r.kind == KIND_ERROR) begin
            r.bad   = c;
            sc_mode = SCAN_HALTED;
          end
          step_out.push_back(r);
        end
      end
      sc_pos = pos_bump(sc_pos);
    end
    if (step_out.size() > 0) begin
      r = step_out.pop_back();
      r.last = 1'b1;
      step_out.push_back(r);
    end
  endfunction

  function automatic dir_row_t typed_row(input logic [7:0] c, input logic eot,
                                         input logic [3:0] kind, input int start,
                                         input logic [7:0] bad);
    dir_row_t d;
    d = '0;
    d.ch          = c;
    d.eot         = eot;
    d.typed       = 1'b1;
    d.want.kind   = kind;
    d.want.start  = 16'(start);
    d.want.length = (kind == KIND_EOF) ? 16'd0 : 16'd1;
    d.want.bad    = bad;
    d.want.last   = 1'b1;
    return d;
  endfunction

  function automatic dir_row_t plain_row(input logic [7:0] c);
    dir_row_t d;
    d = '0;
    d.ch = c;
    return d;
  endfunction

  function automatic logic [7:0] rand_letter();
    logic [7:0] base;
    base = ($urandom_range(0, 1) == 0) ? "a" : "A";
    return base + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_digit();
    return "0" + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_space();
    return ($urandom_range(0, 5) == 5) ? 8'd32 : 8'd9 + 8'($urandom_range(0, 4));
  endfunction

  function automatic logic [7:0] rand_punct();
    return PUNCT_SET[8*$urandom_range(0, 6) +: 8];
  endfunction

  function automatic logic [7:0] rand_invalid();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (is_alpha(c) || is_num(c) || is_ws(c) || punct_of(c) != KIND_ERROR)
      c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  // keywords, their prefixes and near misses
  function automatic string kw_word(input int k);
    case (k)
      0:       return "def";
      1:       return "extern";
      2:       return "de";
      3:       return "defx";
      4:       return "exter";
      5:       return "externs";
      6:       return "ext";
      7:       return "d";
      8:       return "e";
      default: return "define";
    endcase
  endfunction

  function automatic int tx_gap();
    if (tx_burst_left > 0) begin
      tx_burst_left--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) tx_burst_left = $urandom_range(10, 40);
    return $urandom_range(0, 8);
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < 25) $display("MISMATCH @%0t: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic chk_field(input string name, input int unsigned seen, input int unsigned want);
    if (seen != want)
      report_mismatch($sformatf("token %0d %s: got %0d, want %0d", tokens_seen, name, seen, want));
  endtask

  task automatic send_item(input logic [7:0] c, input logic eot, input logic typed,
                           input res_t want);
    int gap;
    gap = tx_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_char_byte   <= c;
    in_end_of_text <= eot;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    if (eot || sc_mode != SCAN_HALTED) live_items++;
    if (eot) texts++;
    scan_byte(c, eot);
    if (typed) pending_tokens.push_back(want);
    else foreach (step_out[k]) pending_tokens.push_back(step_out[k]);
    @(negedge clk);
  endtask

  task automatic push_byte(input logic [7:0] c);
    send_item(c, 1'b0, 1'b0, '0);
  endtask

  task automatic end_text();
    send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
  endtask

  // Mostly well-formed token streams; some noise texts and some texts spoiled by a bad byte.
  task automatic gen_text();
    int    ntok;
    int    t;
    int    j;
    string word;
    bit    spoil;
    ntok = $urandom_range(0, 20);
    if ($urandom_range(0, 7) == 0) begin
      repeat (ntok + 1) push_byte(8'($urandom_range(0, 255)));
    end else begin
      spoil = ($urandom_range(0, 9) == 0);
      for (t = 0; t < ntok; t++) begin
        case ($urandom_range(0, 9))
          0, 1, 2: begin
            push_byte(rand_letter());
            repeat ($urandom_range(0, 8))
              push_byte(($urandom_range(0, 2) == 0) ? rand_digit() : rand_letter());
          end
          3: begin
            word = kw_word($urandom_range(0, 9));
            for (j = 0; j < word.len(); j++) push_byte(word[j]);
          end
          4, 5: repeat ($urandom_range(1, 6)) push_byte(rand_digit());
          6, 7: push_byte(rand_punct());
          default: repeat ($urandom_range(1, 3)) push_byte(rand_space());
        endcase
        // half the tokens butt up against the next one
        if ($urandom_range(0, 1) == 0) push_byte(rand_space());
        if (spoil && t == ntok / 2) begin
          push_byte(rand_invalid());
          repeat ($urandom_range(0, 5)) push_byte(8'($urandom_range(0, 255)));
        end
      end
      if (spoil && ntok > 0) bad_texts++;
    end
    end_text();
  endtask

  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      tokens_seen++;
      if (pending_tokens.size() == 0) begin
        report_mismatch($sformatf("unexpected token kind %0d start %0d",
                                  out_token_kind, out_token_start));
      end else begin
        want = pending_tokens.pop_front();
        chk_field("kind", 32'(out_token_kind), 32'(want.kind));
        chk_field("start", 32'(out_token_start), 32'(want.start));
        chk_field("length", 32'(out_token_length), 32'(want.length));
        chk_field("bad_byte", 32'(out_bad_byte), 32'(want.bad));
        chk_field("last_of_run", 32'(out_last_of_run), 32'(want.last));
      end
      if (rx_burst_left > 0) begin
        rx_burst_left--;
        rx_stall = 0;
      end else begin
        rx_stall = $urandom_range(0, 8);
        if ($urandom_range(0, 39) == 0) rx_burst_left = $urandom_range(10, 40);
      end
    end
  end

  initial begin : result_sink
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_arm) begin
        hold_arm  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int base;
    bit pressed;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_char_byte   = 8'h00;
    in_end_of_text = 1'b0;
    pressed        = 1'b0;
    scan_reset();

    // every punctuation kind, keywords, two-token flushes, error, halt and restart
    dir_rows.push_back(typed_row("(", 1'b0, KIND_LPAREN, 0, 8'h00));
    dir_rows.push_back(typed_row(")", 1'b0, KIND_RPAREN, 1, 8'h00));
    dir_rows.push_back(typed_row("+", 1'b0, KIND_PLUS, 2, 8'h00));
    dir_rows.push_back(typed_row("-", 1'b0, KIND_MINUS, 3, 8'h00));
    dir_rows.push_back(typed_row("*", 1'b0, KIND_STAR, 4, 8'h00));
    dir_rows.push_back(typed_row(",", 1'b0, KIND_COMMA, 5, 8'h00));
    dir_rows.push_back(typed_row(".", 1'b0, KIND_DOT, 6, 8'h00));
    dir_rows.push_back(plain_row("d"));
    dir_rows.push_back(plain_row("e"));
    dir_rows.push_back(plain_row("f"));
    dir_rows.push_back(plain_row(8'd9));
    dir_rows.push_back(plain_row("e"));
    dir_rows.push_back(plain_row("x"));
    dir_rows.push_back(plain_row("t"));
    dir_rows.push_back(plain_row("e"));
    dir_rows.push_back(plain_row("r"));
    dir_rows.push_back(plain_row("n"));
    dir_rows.push_back(plain_row("("));
    dir_rows.push_back(plain_row("9"));
    dir_rows.push_back(plain_row("Z"));
    dir_rows.push_back(plain_row(8'h00));
    dir_rows.push_back(plain_row(8'hFF));
    dir_rows.push_back(typed_row(8'hFF, 1'b1, KIND_EOF, 22, 8'h00));
    dir_rows.push_back(typed_row(8'hFF, 1'b0, KIND_ERROR, 0, 8'hFF));
    dir_rows.push_back(typed_row(8'h00, 1'b1, KIND_EOF, 1, 8'h00));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[r])
      send_item(dir_rows[r].ch, dir_rows[r].eot, dir_rows[r].typed, dir_rows[r].want);

    base = live_items;
    while (live_items - base < RAND_ITEMS) begin
      // halfway: stop draining results while the sender keeps pushing
      if (!pressed && live_items - base > RAND_ITEMS / 2) begin
        pressed       = 1'b1;
        hold_arm      = 1'b1;
        tx_burst_left = 2 * HOLD_CYCLES;
      end
      gen_text();
    end
    in_valid <= 1'b0;

    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Covered %0d live transfers in %0d texts (%0d with a bad byte), %0d tokens.",
             live_items, texts, bad_texts, tokens_seen);
    $display("Included a %0d-cycle output hold-off against a back-to-back sender.",
             HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #6_000_000;
    $display("Timeout with %0d tokens still pending", pending_tokens.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

### sim.f
rtl/core/inpt_pkg.sv
rtl/core/inpt_classify.sv
rtl/core/inpt_scan.sv
rtl/core/inpt_outq.sv
rtl/core/ident_number_punct_tokenizer_top.sv
dv/tb.sv
